/* src/clp_pkg.sv */
package clp_pkg;

  localparam int COORD_W   = 10;
  localparam int PIX_W     = 12;
  localparam int T_W       = 17;
  localparam int NUM_REGS  = 8;
  localparam int CFG_IDX_W = 4;
  localparam int QUEUE_DEPTH = 2;

  // t advance per sample, Q0.16
  localparam int STEP_Q16 = 66;
  localparam logic [T_W-1:0] T_ONE = 17'h10000;

  // one queued sample: parameter value and end-of-curve flag
  typedef struct packed {
    logic [T_W-1:0] t;
    logic           last;
  } q_entry_t;

endpackage

/* src/clp_front.sv */
module clp_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               req_valid,
  output logic               req_ready,
  input  logic               restart,
  output logic               push,
  output clp_pkg::q_entry_t  push_entry,
  input  logic               q_ready
);

  logic [clp_pkg::T_W-1:0] t_accum_r;
  logic [clp_pkg::T_W-1:0] t_accum_nxt;
  logic [clp_pkg::T_W-1:0] t_cur;
  logic [clp_pkg::T_W:0]   t_next;
  logic                    wrap;

  assign req_ready = q_ready;
  assign push      = req_valid && q_ready;

  always_comb begin
    t_cur  = restart ? '0 : t_accum_r;
    t_next = {1'b0, t_cur} + 18'(clp_pkg::STEP_Q16);
    wrap   = t_next > {1'b0, clp_pkg::T_ONE};
    t_accum_nxt = wrap ? '0 : t_next[clp_pkg::T_W-1:0];
    push_entry.t    = t_cur;
    push_entry.last = wrap;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_accum_r <= '0;
    end else if (push) begin
      t_accum_r <= t_accum_nxt;
    end
  end

  a_t_bound: assert property (@(posedge clk) disable iff (!rst_n)
    t_accum_r <= clp_pkg::T_ONE)
    else $error("t accumulator passed 1.0");

  a_wrap_zero: assert property (@(posedge clk) disable iff (!rst_n)
    push && push_entry.last |=> t_accum_r == '0)
    else $error("t not returned to zero after last sample");

endmodule

/* src/clp_queue.sv */
module clp_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  clp_pkg::q_entry_t  push_entry,
  output logic               q_ready,
  input  logic               pop,
  output logic               q_valid,
  output clp_pkg::q_entry_t  pop_entry
);

  localparam int PTR_W = (clp_pkg::QUEUE_DEPTH > 1) ? $clog2(clp_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(clp_pkg::QUEUE_DEPTH + 1);

  clp_pkg::q_entry_t mem_r [clp_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push, do_pop;

  assign q_ready   = count_r != CNT_W'(clp_pkg::QUEUE_DEPTH);
  assign q_valid   = count_r != '0;
  assign do_push   = push && q_ready;
  assign do_pop    = pop && q_valid;
  assign pop_entry = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(clp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(clp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(clp_pkg::QUEUE_DEPTH))
    else $error("queue count overflow");

endmodule

/* src/clp_back.sv */
module clp_back (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 q_valid,
  input  clp_pkg::q_entry_t                    pop_entry,
  output logic                                 pop,
  input  logic [3:0][clp_pkg::COORD_W-1:0]     pts_x,
  input  logic [3:0][clp_pkg::COORD_W-1:0]     pts_y,
  output logic                                 res_valid,
  input  logic                                 res_ready,
  output logic [clp_pkg::PIX_W-1:0]            res_x,
  output logic [clp_pkg::PIX_W-1:0]            res_y,
  output logic                                 res_last
);

  localparam int ACC_W = 70;
  localparam int CF_W  = 18;
  localparam int MA_W  = 27;
  localparam int MP_W  = 45;
  localparam int LO_W  = 26;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LO   = 3'd1;
  localparam logic [2:0] ST_HI   = 3'd2;
  localparam logic [2:0] ST_ADD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  typedef struct packed {
    logic signed [CF_W-1:0] a;
    logic signed [CF_W-1:0] b;
    logic signed [CF_W-1:0] c;
    logic signed [CF_W-1:0] d;
  } coef_t;

  // weighted sums of the doubled basis polynomials, highest power first
  function automatic coef_t calc_coef(input logic [3:0][clp_pkg::COORD_W-1:0] p);
    logic signed [CF_W-1:0] p0, p1, p2, p3;
    coef_t r;
    p0 = CF_W'(p[0]);
    p1 = CF_W'(p[1]);
    p2 = CF_W'(p[2]);
    p3 = CF_W'(p[3]);
    r.a = 18'sd9 * (p3 - p0) + 18'sd27 * (p1 - p2);
    r.b = 18'sd18 * p0 - 18'sd45 * p1 + 18'sd36 * p2 - 18'sd9 * p3;
    r.c = 18'sd18 * p1 - 18'sd11 * p0 - 18'sd9 * p2 + 18'sd2 * p3;
    r.d = 18'sd2 * p0;
    return r;
  endfunction

  logic [2:0]                    state_r, state_nxt;
  logic [1:0]                    step_r, step_nxt;
  logic                          axis_r, axis_nxt;
  logic [clp_pkg::T_W-1:0]       t_r, t_nxt;
  logic                          last_r, last_nxt;
  logic signed [ACC_W-1:0]       x_r, x_nxt;
  logic signed [ACC_W-1:0]       sum_r, sum_nxt;
  logic signed [MP_W-1:0]        prod_r, prod_nxt;
  logic [clp_pkg::PIX_W-1:0]     pix_x_r, pix_x_nxt;
  logic [clp_pkg::PIX_W-1:0]     pix_y_r, pix_y_nxt;
  logic                          res_valid_r, res_valid_nxt;
  logic [clp_pkg::PIX_W-1:0]     res_x_r, res_x_nxt;
  logic [clp_pkg::PIX_W-1:0]     res_y_r, res_y_nxt;
  logic                          res_last_r, res_last_nxt;

  coef_t                         cf;
  logic signed [MA_W-1:0]        mul_a;
  logic signed [MP_W-1:0]        mul_p;
  logic signed [ACC_W-1:0]       addend;
  logic [clp_pkg::PIX_W-1:0]     pix_q;

  assign res_valid = res_valid_r;
  assign res_x     = res_x_r;
  assign res_y     = res_y_r;
  assign res_last  = res_last_r;

  always_comb begin
    // y points from the end of the x pass onwards
    cf = calc_coef((axis_r || state_r == ST_FIN) ? pts_y : pts_x);
    // shared 27x18 multiplier: low limb first, then signed high limb
    mul_a = (state_r == ST_LO) ? $signed({1'b0, x_r[LO_W-1:0]})
                               : $signed(x_r[LO_W+MA_W-1:LO_W]);
    mul_p = mul_a * $signed({1'b0, t_r});
    unique case (step_r)
      2'd0:    addend = {{(ACC_W-CF_W-16){cf.b[CF_W-1]}}, cf.b, 16'b0};
      2'd1:    addend = {{(ACC_W-CF_W-32){cf.c[CF_W-1]}}, cf.c, 32'b0};
      2'd2:    addend = {{(ACC_W-CF_W-48){cf.d[CF_W-1]}}, cf.d, 48'b0};
      default: addend = '0;
    endcase
    // divide by 2^49, truncating toward zero
    pix_q = x_r[60:49] + {{(clp_pkg::PIX_W-1){1'b0}}, x_r[ACC_W-1] && (|x_r[48:0])};
  end

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    axis_nxt      = axis_r;
    t_nxt         = t_r;
    last_nxt      = last_r;
    x_nxt         = x_r;
    sum_nxt       = sum_r;
    prod_nxt      = prod_r;
    pix_x_nxt     = pix_x_r;
    pix_y_nxt     = pix_y_r;
    res_valid_nxt = res_valid_r;
    res_x_nxt     = res_x_r;
    res_y_nxt     = res_y_r;
    res_last_nxt  = res_last_r;
    pop           = 1'b0;

    if (res_valid_r && res_ready) begin
      res_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        axis_nxt = 1'b0;
        if (q_valid) begin
          pop       = 1'b1;
          t_nxt     = pop_entry.t;
          last_nxt  = pop_entry.last;
          step_nxt  = 2'd0;
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        prod_nxt  = mul_p;
        state_nxt = ST_HI;
      end
      ST_HI: begin
        sum_nxt   = {{(ACC_W-MP_W){prod_r[MP_W-1]}}, prod_r} + addend;
        prod_nxt  = mul_p;
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        x_nxt = sum_r + {prod_r[ACC_W-LO_W-1:0], {LO_W{1'b0}}};
        if (step_r == 2'd2) begin
          state_nxt = ST_FIN;
        end else begin
          step_nxt  = step_r + 2'd1;
          state_nxt = ST_LO;
        end
      end
      ST_FIN: begin
        if (!axis_r) begin
          pix_x_nxt = pix_q;
          axis_nxt  = 1'b1;
          step_nxt  = 2'd0;
          state_nxt = ST_LO;
        end else begin
          pix_y_nxt = pix_q;
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        // hold until the output register is free
        if (!res_valid_nxt) begin
          res_valid_nxt = 1'b1;
          res_x_nxt     = pix_x_r;
          res_y_nxt     = pix_y_r;
          res_last_nxt  = last_r;
          axis_nxt      = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase

    // load the leading coefficient when an axis starts
    if ((state_r == ST_IDLE && q_valid) || (state_r == ST_FIN && !axis_r)) begin
      x_nxt = {{(ACC_W-CF_W){cf.a[CF_W-1]}}, cf.a};
    end
  end

  always_ff @(posedge clk) begin
    t_r      <= t_nxt;
    last_r   <= last_nxt;
    x_r      <= x_nxt;
    sum_r    <= sum_nxt;
    prod_r   <= prod_nxt;
    pix_x_r  <= pix_x_nxt;
    pix_y_r  <= pix_y_nxt;
    res_x_r  <= res_x_nxt;
    res_y_r  <= res_y_nxt;
    res_last_r <= res_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= 2'd0;
      axis_r      <= 1'b0;
      res_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      axis_r      <= axis_nxt;
      res_valid_r <= res_valid_nxt;
    end
  end

  a_mul_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_LO |-> (&x_r[ACC_W-1:LO_W+MA_W-1]) || !(|x_r[ACC_W-1:LO_W+MA_W-1]))
    else $error("multiplicand exceeds two limbs");

  a_pix_fits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_FIN |-> (&x_r[ACC_W-1:60]) || !(|x_r[ACC_W-1:60]))
    else $error("curve value out of pixel range");

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == ST_LO && step_r == 2'd0 && !axis_r)
    else $error("sequencer not started on pop");

endmodule

/* src/cubic_lagrange_curve_plotter.sv */
// An accepted request is stored in the queue; the back end then evaluates x and then y before raising out_tvalid.
// Throughput is set by the single shared 27x18 multiplier, which runs three Horner steps
// of two limbs each for x and then for y, one sample at a time.
// Requests are taken at one per cycle while the two-entry queue has room.
// Reset (rst_n low at a clock edge) zeroes t, the control points and the queue.
module cubic_lagrange_curve_plotter (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [0] restart, [7:1] zero
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [23:0]                     out_tdata,  // [11:0] pix_x, [23:12] pix_y
  output logic                            out_tlast,  // last_sample
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [clp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [clp_pkg::COORD_W-1:0]     cfg_data
);

  logic [clp_pkg::COORD_W-1:0]         regs_r [clp_pkg::NUM_REGS];
  logic [3:0][clp_pkg::COORD_W-1:0]    pts_x, pts_y;
  logic                                push, q_ready, q_valid, pop;
  clp_pkg::q_entry_t                   push_entry, pop_entry;
  logic [clp_pkg::PIX_W-1:0]           res_x, res_y;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < clp_pkg::NUM_REGS; i++) begin
        regs_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_index < clp_pkg::CFG_IDX_W'(clp_pkg::NUM_REGS)) begin
      regs_r[cfg_index[2:0]] <= cfg_data;
    end
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      pts_x[i] = regs_r[2*i];
      pts_y[i] = regs_r[2*i+1];
    end
  end

  clp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .req_valid  (in_tvalid),
    .req_ready  (in_tready),
    .restart    (in_tdata[0]),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready)
  );

  clp_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .q_ready    (q_ready),
    .pop        (pop),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry)
  );

  clp_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_valid    (q_valid),
    .pop_entry  (pop_entry),
    .pop        (pop),
    .pts_x      (pts_x),
    .pts_y      (pts_y),
    .res_valid  (out_tvalid),
    .res_ready  (out_tready),
    .res_x      (res_x),
    .res_y      (res_y),
    .res_last   (out_tlast)
  );

  assign out_tdata = {res_y, res_x};

endmodule
